// ===== hdl/kfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// kfsp_pkg
// Shared types, widths and helpers for the keyframe camera path block.
// ----------------------------------------------------------------------------
package kfsp_pkg;

  // default table depth
  localparam int unsigned MAX_KEYS_DEF = 16;

  // field widths
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned NUM_CRD = 6;
  localparam int unsigned FRAC_W  = 17;

  // divider widths: 40-bit dividend, 24-bit divisor
  localparam int unsigned DIV_W = 40;
  localparam int unsigned DEN_W = 24;
  localparam int unsigned DCNT_W = 6;

  // stored keyframe: position x/y/z in slots 0..2, target x/y/z in slots 3..5
  typedef struct packed {
    logic [TIME_W-1:0]                time_val;
    logic [NUM_CRD-1:0][CRD_W-1:0]    crd;
    logic [CRD_W-1:0]                 ang;
  } key_t;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_NEW,
    ST_EV_DUR,
    ST_EV_MOD,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_EV_FRAC,
    ST_FETCH,
    ST_POW1,
    ST_POW2,
    ST_SPLINE,
    ST_FOV,
    ST_FIN
  } state_e;

  // saturate a 25-bit signed value to 16 bits
  function automatic logic [CRD_W-1:0] sat16(input logic signed [24:0] v);
    logic [CRD_W-1:0] r;
    if (v > 25'sd32767) begin
      r = 16'h7fff;
    end else if (v < -25'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/kfsp_div.sv =====
// ----------------------------------------------------------------------------
// kfsp_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module kfsp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kfsp_pkg::DIV_W-1:0]    dividend_i,
  input  logic [kfsp_pkg::DEN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [kfsp_pkg::DIV_W-1:0]    quot_o,
  output logic [kfsp_pkg::DEN_W-1:0]    rem_o
);

  logic                         run_q;
  logic                         done_q;
  logic [kfsp_pkg::DCNT_W-1:0]  cnt_q;
  logic [kfsp_pkg::DIV_W-1:0]   num_q;
  logic [kfsp_pkg::DEN_W-1:0]   rem_q;
  logic [kfsp_pkg::DEN_W-1:0]   den_q;
  logic [kfsp_pkg::DEN_W:0]     trial;
  logic [kfsp_pkg::DEN_W:0]     diff;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, num_q[kfsp_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == kfsp_pkg::DCNT_W'(kfsp_pkg::DIV_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (!diff[kfsp_pkg::DEN_W]) begin
        rem_q <= diff[kfsp_pkg::DEN_W-1:0];
        num_q <= {num_q[kfsp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[kfsp_pkg::DEN_W-1:0];
        num_q <= {num_q[kfsp_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/keyframe_spline_camera_path.sv =====
// ----------------------------------------------------------------------------
// keyframe_spline_camera_path
// Time-ordered keyframe memory with a Catmull-Rom camera path evaluator.
// ----------------------------------------------------------------------------
// Usage: drive a command with start; it transfers at a clock edge where start
// is high and busy is low. Command 0 inserts a keyframe in time order (after
// keys of equal time); an insert into a full memory is dropped. Command 1
// evaluates the path at time_value and produces one result, shown for exactly
// one cycle with result_valid_o; nothing comes out with fewer than two keys.
// The receiver cannot stall, so a result is never held back.
// loop_enable is written through cfg_we_i / cfg_wdata_i; the user must do so
// only while busy is low (the block does not enforce this). An insert moves each
// later key up one slot (the first key is written directly); each key shift is
// a read and a write of the single keyframe memory. An evaluate reads the
// duration, searches the keys (at least two), runs up to two divisions (time
// wrap and segment fraction) in the bit-serial divider, fetches four keys,
// forms the powers, runs the shared spline multiplier and finishes while busy
// is high, with the result in the cycle after the last busy cycle. A dropped
// command leaves busy low. Reset empties the memory (count 0) and clears
// loop_enable; the keyframe memory is not cleared.
// ----------------------------------------------------------------------------
module keyframe_spline_camera_path #(
  parameter int unsigned MAX_KEYS = kfsp_pkg::MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [23:0] time_value_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [15:0] aim_x_i,
  input  logic [15:0] aim_y_i,
  input  logic [15:0] aim_z_i,
  input  logic [15:0] view_angle_i,
  output logic        result_valid_o,
  output logic [15:0] cam_x_o,
  output logic [15:0] cam_y_o,
  output logic [15:0] cam_z_o,
  output logic [15:0] dir_x_o,
  output logic [15:0] dir_y_o,
  output logic [15:0] dir_z_o,
  output logic [15:0] zoom_angle_o
);

  localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned TW = kfsp_pkg::TIME_W;
  localparam int unsigned FW = kfsp_pkg::FRAC_W;

  // keyframe memory, registered read
  kfsp_pkg::key_t key_mem_q [MAX_KEYS];
  kfsp_pkg::key_t rdata_q;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [IW-1:0]  mem_raddr;
  kfsp_pkg::key_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= key_mem_q[mem_raddr];
  end

  kfsp_pkg::state_e state_q, state_d;
  logic [CW-1:0]  cnt_q;
  logic           loop_q;
  kfsp_pkg::key_t ins_q;
  logic [IW-1:0]  k_q;
  logic [TW-1:0]  lt_q;
  logic [TW-1:0]  prev_q;
  logic [IW-1:0]  j_q;
  logic [IW-1:0]  i_q;
  logic [FW-1:0]  u_q, u2_q, u3_q;
  logic [2:0]     fc_q;
  kfsp_pkg::key_t row_q [4];
  logic [2:0]     ci_q;
  logic [1:0]     ks_q;
  logic signed [39:0] acc_q;
  logic signed [38:0] prod_q;
  logic signed [23:0] res_q [kfsp_pkg::NUM_CRD];
  logic signed [34:0] fprod_q;
  logic           valid_q;
  logic [15:0]    cam_q [3];
  logic [15:0]    dir_q [3];
  logic [15:0]    zoom_q;

  // divider hookup
  logic                        div_start;
  logic [kfsp_pkg::DIV_W-1:0]  div_num;
  logic [kfsp_pkg::DEN_W-1:0]  div_den;
  logic                        div_done;
  logic [kfsp_pkg::DIV_W-1:0]  div_quot;
  logic [kfsp_pkg::DEN_W-1:0]  div_rem;

  kfsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // segment end indices, clamped into the stored range
  logic [CW:0]    i_ext;
  logic [IW-1:0]  idx0, idx2, idx3;
  logic [IW-1:0]  fetch_addr;
  assign i_ext = {{(CW + 1 - IW){1'b0}}, i_q};
  assign idx0  = (i_q == '0) ? '0 : i_q - 1'b1;
  assign idx2  = i_q + 1'b1;
  assign idx3  = ((i_ext + 2'd2) < {1'b0, cnt_q}) ? IW'(i_ext + 2'd2)
                                                   : IW'(cnt_q - 1'b1);
  always_comb begin
    unique case (fc_q[1:0])
      2'd0:    fetch_addr = idx0;
      2'd1:    fetch_addr = i_q;
      2'd2:    fetch_addr = idx2;
      default: fetch_addr = idx3;
    endcase
  end

  // evaluate-time helpers
  logic [TW-1:0] dur;
  logic [TW-1:0] seg_len;
  logic          last_seg;
  assign dur      = rdata_q.time_val;
  assign seg_len  = rdata_q.time_val - prev_q;
  assign last_seg = ({{(CW - IW){1'b0}}, j_q} == (cnt_q - 1'b1));

  // spline coefficients for the current coordinate
  logic signed [20:0] p0, p1, p2, p3;
  logic signed [20:0] coef;
  logic signed [17:0] pw;
  logic signed [38:0] mul;
  logic signed [39:0] acc_sum;
  assign p0 = 21'(signed'(row_q[0].crd[ci_q]));
  assign p1 = 21'(signed'(row_q[1].crd[ci_q]));
  assign p2 = 21'(signed'(row_q[2].crd[ci_q]));
  assign p3 = 21'(signed'(row_q[3].crd[ci_q]));
  always_comb begin
    unique case (ks_q)
      2'd0: begin
        coef = p2 - p0;
        pw   = signed'({1'b0, u_q});
      end
      2'd1: begin
        coef = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        pw   = signed'({1'b0, u2_q});
      end
      default: begin
        coef = p1 + (p1 <<< 1) - p2 - (p2 <<< 1) - p0 + p3;
        pw   = signed'({1'b0, u3_q});
      end
    endcase
  end
  assign mul     = 39'(coef) * 39'(pw);
  assign acc_sum = acc_q + 40'(prod_q);

  // field-of-view mix
  logic signed [16:0] fdiff;
  logic signed [34:0] fround;
  assign fdiff  = signed'({1'b0, row_q[2].ang}) - signed'({1'b0, row_q[1].ang});
  assign fround = fprod_q + 35'sd32768;

  // next state and memory / divider control
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = ins_q;
    mem_raddr = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = dur;
    unique case (state_q)
      kfsp_pkg::ST_IDLE: begin
        if (start) begin
          if (command_i == kfsp_pkg::CMD_INSERT) begin
            if (cnt_q == CW'(MAX_KEYS)) begin
              state_d = kfsp_pkg::ST_IDLE;
            end else if (cnt_q == '0) begin
              mem_we    = 1'b1;
              mem_wdata = '{time_val: time_value_i,
                            crd: {aim_z_i, aim_y_i, aim_x_i, pos_z_i, pos_y_i, pos_x_i},
                            ang: view_angle_i};
            end else begin
              state_d = kfsp_pkg::ST_INS_RD;
            end
          end else if (cnt_q >= CW'(2)) begin
            mem_raddr = IW'(cnt_q - 1'b1);
            state_d   = kfsp_pkg::ST_EV_DUR;
          end
        end
      end
      kfsp_pkg::ST_INS_RD: begin
        mem_raddr = k_q;
        state_d   = kfsp_pkg::ST_INS_CHK;
      end
      kfsp_pkg::ST_INS_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = k_q + 1'b1;
        if (rdata_q.time_val > ins_q.time_val) begin
          mem_wdata = rdata_q;
          state_d   = (k_q == '0) ? kfsp_pkg::ST_INS_NEW : kfsp_pkg::ST_INS_RD;
        end else begin
          state_d = kfsp_pkg::ST_IDLE;
        end
      end
      kfsp_pkg::ST_INS_NEW: begin
        mem_we  = 1'b1;
        state_d = kfsp_pkg::ST_IDLE;
      end
      kfsp_pkg::ST_EV_DUR: begin
        if (loop_q && dur != '0) begin
          div_start = 1'b1;
          div_num   = {{(kfsp_pkg::DIV_W - TW){1'b0}}, ins_q.time_val};
          state_d   = kfsp_pkg::ST_EV_MOD;
        end else begin
          state_d = kfsp_pkg::ST_SRCH_RD;
        end
      end
      kfsp_pkg::ST_EV_MOD: begin
        if (div_done) begin
          state_d = kfsp_pkg::ST_SRCH_RD;
        end
      end
      kfsp_pkg::ST_SRCH_RD: begin
        mem_raddr = j_q;
        state_d   = kfsp_pkg::ST_SRCH_CHK;
      end
      kfsp_pkg::ST_SRCH_CHK: begin
        if (j_q == '0) begin
          state_d = kfsp_pkg::ST_SRCH_RD;
        end else if (lt_q <= rdata_q.time_val || last_seg) begin
          if (seg_len == '0 || lt_q <= prev_q) begin
            state_d = kfsp_pkg::ST_FETCH;
          end else begin
            div_start = 1'b1;
            div_num   = {lt_q - prev_q, 16'h0000};
            div_den   = seg_len;
            state_d   = kfsp_pkg::ST_EV_FRAC;
          end
        end else begin
          state_d = kfsp_pkg::ST_SRCH_RD;
        end
      end
      kfsp_pkg::ST_EV_FRAC: begin
        if (div_done) begin
          state_d = kfsp_pkg::ST_FETCH;
        end
      end
      kfsp_pkg::ST_FETCH: begin
        mem_raddr = fetch_addr;
        if (fc_q == 3'd4) begin
          state_d = kfsp_pkg::ST_POW1;
        end
      end
      kfsp_pkg::ST_POW1: state_d = kfsp_pkg::ST_POW2;
      kfsp_pkg::ST_POW2: state_d = kfsp_pkg::ST_SPLINE;
      kfsp_pkg::ST_SPLINE: begin
        if (ks_q == 2'd3 && ci_q == 3'(kfsp_pkg::NUM_CRD - 1)) begin
          state_d = kfsp_pkg::ST_FOV;
        end
      end
      kfsp_pkg::ST_FOV: state_d = kfsp_pkg::ST_FIN;
      kfsp_pkg::ST_FIN: state_d = kfsp_pkg::ST_IDLE;
      default: state_d = kfsp_pkg::ST_IDLE;
    endcase
  end

  // state, count and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfsp_pkg::ST_IDLE;
      cnt_q   <= '0;
      loop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == kfsp_pkg::ST_FIN);
      if (cfg_we_i) begin
        loop_q <= cfg_wdata_i;
      end
      // count grows when the new key lands
      if ((state_q == kfsp_pkg::ST_IDLE && start && command_i == kfsp_pkg::CMD_INSERT
           && cnt_q == '0)
          || (state_q == kfsp_pkg::ST_INS_CHK && !(rdata_q.time_val > ins_q.time_val))
          || state_q == kfsp_pkg::ST_INS_NEW) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kfsp_pkg::ST_IDLE: begin
        ins_q <= '{time_val: time_value_i,
                   crd: {aim_z_i, aim_y_i, aim_x_i, pos_z_i, pos_y_i, pos_x_i},
                   ang: view_angle_i};
        k_q   <= IW'(cnt_q - 1'b1);
        j_q   <= '0;
        fc_q  <= '0;
        u_q   <= '0;
      end
      kfsp_pkg::ST_INS_CHK: begin
        k_q <= k_q - 1'b1;
      end
      kfsp_pkg::ST_EV_DUR: begin
        if (loop_q) begin
          lt_q <= '0;
        end else begin
          lt_q <= (ins_q.time_val < dur) ? ins_q.time_val : dur;
        end
      end
      kfsp_pkg::ST_EV_MOD: begin
        lt_q <= div_rem;
      end
      kfsp_pkg::ST_SRCH_CHK: begin
        prev_q <= rdata_q.time_val;
        j_q    <= j_q + 1'b1;
        i_q    <= j_q - 1'b1;
      end
      kfsp_pkg::ST_EV_FRAC: begin
        u_q <= div_quot[FW-1:0];
      end
      kfsp_pkg::ST_FETCH: begin
        fc_q <= fc_q + 1'b1;
        if (fc_q != 3'd0) begin
          row_q[fc_q[1:0] - 2'd1] <= rdata_q;
        end
      end
      kfsp_pkg::ST_POW1: begin
        u2_q <= FW'(((34'(u_q) * 34'(u_q)) + 34'd32768) >> 16);
      end
      kfsp_pkg::ST_POW2: begin
        u3_q <= FW'(((34'(u2_q) * 34'(u_q)) + 34'd32768) >> 16);
        ci_q <= '0;
        ks_q <= '0;
      end
      kfsp_pkg::ST_SPLINE: begin
        ks_q <= ks_q + 1'b1;
        if (ks_q != 2'd3) begin
          prod_q <= mul;
        end
        if (ks_q == 2'd0) begin
          acc_q <= (40'(p1) <<< 17) + 40'sd65536;
        end else begin
          acc_q <= acc_sum;
        end
        if (ks_q == 2'd3) begin
          res_q[ci_q] <= 24'(acc_sum >>> 17);
          ci_q        <= ci_q + 1'b1;
        end
      end
      kfsp_pkg::ST_FOV: begin
        fprod_q <= 35'(fdiff) * 35'(signed'({1'b0, u_q}));
      end
      kfsp_pkg::ST_FIN: begin
        for (int c = 0; c < 3; c++) begin
          cam_q[c] <= kfsp_pkg::sat16(25'(res_q[c]));
          dir_q[c] <= kfsp_pkg::sat16(25'(res_q[c + 3]) - 25'(res_q[c]));
        end
        zoom_q <= row_q[1].ang + 16'(fround >>> 16);
      end
      default: begin
      end
    endcase
  end

  assign busy           = (state_q != kfsp_pkg::ST_IDLE);
  assign result_valid_o = valid_q;
  assign cam_x_o        = cam_q[0];
  assign cam_y_o        = cam_q[1];
  assign cam_z_o        = cam_q[2];
  assign dir_x_o        = dir_q[0];
  assign dir_y_o        = dir_q[1];
  assign dir_z_o        = dir_q[2];
  assign zoom_angle_o   = zoom_q;

endmodule

// ===== hdl/kfsp_chk.sv =====
// ----------------------------------------------------------------------------
// kfsp_chk
// Port-level checks for the keyframe camera path block, bound to the top.
// ----------------------------------------------------------------------------
module kfsp_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic command_i,
  input logic result_valid_o
);

  // a result is a single-cycle strobe
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // an evaluate transfer is never directly followed by a result
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i) |=> !result_valid_o)
    else $error("result right after an evaluate transfer");

  // a result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // the block is idle when the result is shown
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while the result is shown");

endmodule

bind keyframe_spline_camera_path kfsp_chk u_kfsp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o)
);

// ===== sim/kfsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_checker
// Watches the command, config and result channels of the keyframe camera
// path, keeps its own keyframe table, predicts every result and compares.
// ----------------------------------------------------------------------------
module kfsp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start,
  input  logic        busy,
  input  logic        command_i,
  input  logic [23:0] time_value_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [15:0] aim_x_i,
  input  logic [15:0] aim_y_i,
  input  logic [15:0] aim_z_i,
  input  logic [15:0] view_angle_i,
  input  logic        result_valid_o,
  input  logic [15:0] cam_x_o,
  input  logic [15:0] cam_y_o,
  input  logic [15:0] cam_z_o,
  input  logic [15:0] dir_x_o,
  input  logic [15:0] dir_y_o,
  input  logic [15:0] dir_z_o,
  input  logic [15:0] zoom_angle_o,
  output int          fail_count_o,
  output int          pending_views_o
);
  import kfsp_pkg::*;

  localparam int unsigned DEPTH = MAX_KEYS_DEF;

  // one camera view: cam x/y/z, dir x/y/z, zoom
  typedef logic [6:0][15:0] cam_view_t;

  cam_view_t   expected_views[$];
  logic [23:0] key_time[DEPTH];
  longint      key_pos[DEPTH][3];
  longint      key_aim[DEPTH][3];
  logic [15:0] key_ang[DEPTH];
  int unsigned key_num;
  bit          wrap_mode;
  int          fails;
  int          pending;

  assign fail_count_o    = fails;
  assign pending_views_o = pending;

  function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                         longint u, longint u2, longint u3);
    longint s;
    s = 2 * p1 * 65536 + (p2 - p0) * u + (2 * p0 - 5 * p1 + 4 * p2 - p3) * u2
      + (-p0 + 3 * p1 - 3 * p2 + p3) * u3;
    return (s + 65536) >>> 17;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // insert keyframe in time order, or queue the predicted view of an evaluate
  task automatic apply_command(logic cmd, logic [23:0] t, logic [5:0][15:0] crd,
                               logic [15:0] ang);
    int unsigned p, i, i0, i2, i3;
    logic [23:0] dur, lt, seg_len;
    longint u, u2, u3, pv, tv, f1, f2;
    bit found;
    cam_view_t view;
    if (cmd == CMD_INSERT) begin
      if (key_num >= DEPTH) return;
      p = 0;
      while (p < key_num && key_time[p] <= t) p++;
      for (int k = key_num; k > p; k--) begin
        key_time[k] = key_time[k-1];
        key_ang[k]  = key_ang[k-1];
        key_pos[k]  = key_pos[k-1];
        key_aim[k]  = key_aim[k-1];
      end
      key_time[p] = t;
      key_ang[p]  = ang;
      for (int c = 0; c < 3; c++) begin
        key_pos[p][c] = longint'($signed(crd[c]));
        key_aim[p][c] = longint'($signed(crd[3+c]));
      end
      key_num++;
      return;
    end
    if (key_num < 2) return;
    dur = key_time[key_num-1];
    if (wrap_mode) lt = (dur == 0) ? 24'd0 : t % dur;
    else lt = (t < dur) ? t : dur;
    // segment search and fraction
    found = 0;
    u = 65536;
    for (i = 0; i + 1 < key_num; i++) begin
      if (lt <= key_time[i+1]) begin
        seg_len = key_time[i+1] - key_time[i];
        if (seg_len == 0 || lt <= key_time[i]) u = 0;
        else u = ((longint'(lt - key_time[i])) << 16) / longint'(seg_len);
        found = 1;
        break;
      end
    end
    if (!found) begin
      i = key_num - 2;
      u = 65536;
    end
    i0 = (i == 0) ? 0 : i - 1;
    i2 = (i + 1 < key_num) ? i + 1 : key_num - 1;
    i3 = (i + 2 < key_num) ? i + 2 : key_num - 1;
    u2 = (u * u + 32768) >>> 16;
    u3 = (u2 * u + 32768) >>> 16;
    for (int c = 0; c < 3; c++) begin
      pv = catmull_rom(key_pos[i0][c], key_pos[i][c], key_pos[i2][c], key_pos[i3][c],
                       u, u2, u3);
      tv = catmull_rom(key_aim[i0][c], key_aim[i][c], key_aim[i2][c], key_aim[i3][c],
                       u, u2, u3);
      view[c]   = clip16(pv);
      view[3+c] = clip16(tv - pv);
    end
    f1 = key_ang[i];
    f2 = key_ang[i2];
    view[6] = 16'((f1 * (65536 - u) + f2 * u + 32768) >>> 16);
    expected_views = {expected_views, view};
  endtask

  // compare results, then follow config writes and command transfers
  always @(posedge clk_i or negedge rst_ni) begin
    cam_view_t want, got;
    string names[7];
    if (!rst_ni) begin
      key_num   = 0;
      wrap_mode = 0;
      fails     = 0;
      expected_views.delete();
      pending   = 0;
    end else begin
      names = '{"cam_x", "cam_y", "cam_z", "dir_x", "dir_y", "dir_z", "zoom_angle"};
      if (result_valid_o) begin
        got = {zoom_angle_o, dir_z_o, dir_y_o, dir_x_o, cam_z_o, cam_y_o, cam_x_o};
        if (expected_views.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, actual %h", $time, got);
        end else begin
          want = expected_views.pop_front();
          for (int f = 0; f < 7; f++) begin
            if (got[f] !== want[f]) begin
              fails++;
              $display("%0t: %s mismatch, expected %h, actual %h", $time, names[f],
                       want[f], got[f]);
            end
          end
        end
      end
      if (cfg_we_i) wrap_mode = cfg_wdata_i;
      if (start && !busy) begin
        apply_command(command_i, time_value_i,
                      {aim_z_i, aim_y_i, aim_x_i, pos_z_i, pos_y_i, pos_x_i},
                      view_angle_i);
      end
      pending = expected_views.size();
    end
  end

endmodule

// ===== sim/tb_keyframe_spline_camera_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_spline_camera_path
// Drives insert and evaluate commands into the camera path block under both
// loop settings and varying sender gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_keyframe_spline_camera_path;
  import kfsp_pkg::*;

  logic        clk_i, rst_ni, cfg_we_i, cfg_wdata_i, start, busy, command_i;
  logic [23:0] time_value_i;
  logic [15:0] pos_x_i, pos_y_i, pos_z_i, aim_x_i, aim_y_i, aim_z_i, view_angle_i;
  logic        result_valid_o;
  logic [15:0] cam_x_o, cam_y_o, cam_z_o, dir_x_o, dir_y_o, dir_z_o, zoom_angle_o;
  int          fail_count, pending_views;
  int          gap_pct;
  int unsigned keys_sent;
  logic [23:0] last_key_time;

  keyframe_spline_camera_path i_dut (.*);
  kfsp_checker i_checker (.*, .fail_count_o(fail_count), .pending_views_o(pending_views));

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #20ms;
    $display("tb_keyframe_spline_camera_path: FAIL");
    $finish;
  end

  // one command transfer, start stays high afterwards
  task automatic send_cmd(logic cmd, logic [23:0] t, logic [15:0] px, logic [15:0] py,
                          logic [15:0] pz, logic [15:0] ax, logic [15:0] ay,
                          logic [15:0] az, logic [15:0] va);
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start        <= 1;
    command_i    <= cmd;
    time_value_i <= t;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    aim_x_i <= ax; aim_y_i <= ay; aim_z_i <= az;
    view_angle_i <= va;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == CMD_INSERT && keys_sent < MAX_KEYS_DEF) begin
      keys_sent++;
      if (t > last_key_time) last_key_time = t;
    end
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  task automatic insert_key(logic [23:0] t);
    send_cmd(CMD_INSERT, t, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), 16'($urandom));
  endtask

  task automatic query(logic [23:0] t);
    send_cmd(CMD_EVAL, t, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait until idle and all views are in, then let a dropped evaluate finish
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (pending_views != 0 || busy) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_loop(bit v);
    drain();
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0; cfg_wdata_i = 0; start = 0; command_i = 0; time_value_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0; aim_x_i = 0; aim_y_i = 0; aim_z_i = 0;
    view_angle_i = 0;
    gap_pct = 19;
    keys_sent = 0;
    last_key_time = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: too few keys, extremes, equal times, before first key
    set_loop(0);
    query(24'h000000);
    send_cmd(CMD_INSERT, 24'h000100, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
             16'h8000, 16'h0000);
    query(24'h000100);
    send_cmd(CMD_INSERT, 24'h000100, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
             16'h7fff, 16'hffff);
    query(24'h000010);
    query(24'hffffff);
    send_cmd(CMD_INSERT, 24'h000400, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff,
             16'h0001, 16'h8000);
    send_cmd(CMD_INSERT, 24'h000400, 16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000,
             16'h0000, 16'h00ff);
    send_cmd(CMD_INSERT, 24'hffffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
             16'h7fff, 16'hff00);
    query(24'h000000);
    query(24'h000280);
    query(24'h000400);
    query(24'h800000);
    query(24'hffffff);
    set_loop(1);
    query(24'hffffff);
    query(24'h000000);
    query(24'h000401);
    query(24'hfffffe);

    // random: fill the table, then mostly evaluate
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 19 : (ph == 1) ? 79 : 0;
      set_loop(ph[0] == 0);
      for (int n = 0; n < 160; n++) begin
        if (keys_sent < MAX_KEYS_DEF ? $urandom_range(2) == 0 : $urandom_range(19) == 0) begin
          insert_key($urandom_range(3) == 0 ? last_key_time
                                            : 24'($urandom_range(24'h000100, 24'h00ffff)));
        end else begin
          case ($urandom_range(4))
            0: query(24'($urandom));
            1: query(24'($urandom_range(0, 24'h000100)));
            default: query(24'($urandom_range(0, last_key_time + 24'h000100)));
          endcase
        end
        if (n == 80) set_loop($urandom_range(1));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_keyframe_spline_camera_path: PASS");
    end else begin
      $display("tb_keyframe_spline_camera_path: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kfsp_pkg.sv
hdl/kfsp_div.sv
hdl/keyframe_spline_camera_path.sv
hdl/kfsp_chk.sv
sim/kfsp_checker.sv
sim/tb_keyframe_spline_camera_path.sv
